FILE: hw/rtl/adre_pkg.sv
package adre_pkg;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_IRQ     = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;
	localparam logic [1:0] ACT_RESTART = 2'd3;

	localparam logic [2:0] KIND_CMD     = 3'd0;
	localparam logic [2:0] KIND_WCHUNK  = 3'd1;
	localparam logic [2:0] KIND_RCHUNK  = 3'd2;
	localparam logic [2:0] KIND_DONE    = 3'd3;
	localparam logic [2:0] KIND_REQUEUE = 3'd4;

	localparam logic [2:0] CMD_READ_DMA    = 3'd0;
	localparam logic [2:0] CMD_WRITE_DMA   = 3'd1;
	localparam logic [2:0] CMD_READ_MULTI  = 3'd2;
	localparam logic [2:0] CMD_WRITE_MULTI = 3'd3;
	localparam logic [2:0] CMD_READ        = 3'd4;
	localparam logic [2:0] CMD_WRITE       = 3'd5;

	localparam logic [2:0] REG_LBA_ENABLE  = 3'd0;
	localparam logic [2:0] REG_SPT         = 3'd1;
	localparam logic [2:0] REG_HEAD_COUNT  = 3'd2;
	localparam logic [2:0] REG_SPI         = 3'd3;
	localparam logic [2:0] REG_DMA_ALLOWED = 3'd4;

	localparam logic [2:0] MAX_RETRIES = 3'd3;
	localparam logic [9:0] MAX_SECTORS = 10'd256;
	localparam logic [2:0] RETRY_SAT   = 3'd7;

	typedef struct packed {
		logic        lba_enable;
		logic [7:0]  sectors_per_track;
		logic [4:0]  head_count;
		logic [4:0]  sectors_per_interrupt;
		logic        dma_allowed;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [27:0] block_address;
		logic [17:0] byte_count;
		logic        is_read;
		logic        dma_setup_ok;
		logic        status_error;
		logic        crc_error;
		logic        dma_done_ok;
		logic        data_ready;
	} item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [2:0]  command_code;
		logic [15:0] cylinder;
		logic [3:0]  head;
		logic [7:0]  sector;
		logic [8:0]  sector_count;
		logic        lba_mode;
		logic [17:0] chunk_offset;
		logic [17:0] chunk_bytes;
		logic        failed;
		logic [17:0] residual;
		logic        last;
	} res_t;

endpackage

FILE: hw/rtl/adre_front.sv
module adre_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  adre_pkg::item_t in_item,
	output logic            item_valid,
	output adre_pkg::item_t item,
	input  logic            item_pop
);

	adre_pkg::item_t ent_q [2];
	logic            rd_q;
	logic            wr_q;
	logic [1:0]      cnt_q;
	logic            do_push;

	assign full       = (cnt_q == 2'd2);
	assign do_push    = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (item_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, item_pop};
		end
	end

endmodule

FILE: hw/rtl/adre_div.sv
module adre_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [27:0] dividend,
	input  logic [12:0] divisor,
	output logic        done,
	output logic [27:0] quotient,
	output logic [12:0] remainder
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [27:0] quo_q;
	logic [12:0] rem_q;
	logic [12:0] div_q;
	logic [13:0] trial;
	logic        ge;
	logic [13:0] diff;

	assign trial     = {rem_q, quo_q[27]};
	assign ge        = (trial >= {1'b0, div_q});
	assign diff      = trial - {1'b0, div_q};
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 13'd0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[26:0], ge};
			rem_q <= ge ? diff[12:0] : trial[12:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd27) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/adre_back.sv
module adre_back (
	input  logic            clk,
	input  logic            arst_n,
	input  adre_pkg::cfg_t  cfg,
	input  logic            item_valid,
	input  adre_pkg::item_t item,
	output logic            item_pop,
	output logic            empty,
	input  logic            pop,
	output adre_pkg::res_t  res
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DISP   = 4'd1;
	localparam logic [3:0] ST_INTCHK = 4'd2;
	localparam logic [3:0] ST_XFER   = 4'd3;
	localparam logic [3:0] ST_DIV1   = 4'd4;
	localparam logic [3:0] ST_DIV2   = 4'd5;
	localparam logic [3:0] ST_CMD    = 4'd6;
	localparam logic [3:0] ST_TAIL   = 4'd7;
	localparam logic [3:0] ST_FIN    = 4'd8;

	logic [3:0]      state_q;
	adre_pkg::item_t item_q;
	logic [27:0]     start_block_q;
	logic [17:0]     rem_q;
	logic [17:0]     done_q;
	logic [17:0]     chunk_q;
	logic            reading_q;
	logic            dma_q;
	logic [2:0]      retry_q;
	logic            fallen_q;
	logic [15:0]     cyl_q;
	logic [3:0]      hd_q;
	logic [7:0]      sec_q;
	adre_pkg::res_t  pend_q;
	logic            pend_v_q;

	adre_pkg::res_t  oq_q [4];
	logic [1:0]      oq_rd_q;
	logic [1:0]      oq_wr_q;
	logic [2:0]      oq_cnt_q;

	logic [7:0]      spt_eff;
	logic [4:0]      hc_eff;
	logic [4:0]      spi_eff;
	logic [12:0]     spc;
	logic [17:0]     xfer;
	logic [17:0]     cur_min;
	logic [17:0]     rem_sub;
	logic [18:0]     cnt_sum;
	logic [9:0]      cnt_raw;
	logic [8:0]      sec_cnt;
	logic            use_dma;
	logic            irq_err;
	logic            tmo_fb;
	logic [2:0]      retry0;
	logic            tmo_req;
	logic [2:0]      cmd_code;

	logic            div_start;
	logic [27:0]     div_dividend;
	logic [12:0]     div_divisor;
	logic            div_done;
	logic [27:0]     div_quo;
	logic [12:0]     div_rem;

	logic            emit;
	adre_pkg::res_t  emit_res;
	logic            fin;
	logic            push;
	adre_pkg::res_t  push_res;
	logic            do_pop;

	assign spt_eff = (cfg.sectors_per_track == 8'd0) ? 8'd1 : cfg.sectors_per_track;
	assign hc_eff  = (cfg.head_count == 5'd0) ? 5'd1 : cfg.head_count;
	assign spi_eff = (cfg.sectors_per_interrupt == 5'd0) ? 5'd1 : cfg.sectors_per_interrupt;
	assign spc     = {5'd0, spt_eff} * {8'd0, hc_eff};
	assign xfer    = {4'd0, spi_eff, 9'd0};
	assign cur_min = (rem_q < xfer) ? rem_q : xfer;
	assign rem_sub = (rem_q > chunk_q) ? (rem_q - chunk_q) : 18'd0;
	assign cnt_sum = {1'b0, rem_q} + 19'd511;
	assign cnt_raw = cnt_sum[18:9];
	assign sec_cnt = (cnt_raw > adre_pkg::MAX_SECTORS) ? adre_pkg::MAX_SECTORS[8:0]
		: cnt_raw[8:0];
	assign use_dma = cfg.dma_allowed && !fallen_q && item_q.dma_setup_ok;
	assign irq_err = item_q.status_error || (dma_q && !item_q.dma_done_ok)
		|| (!dma_q && reading_q && !item_q.data_ready);
	assign tmo_fb  = dma_q && (retry_q == adre_pkg::MAX_RETRIES);
	assign retry0  = tmo_fb ? 3'd0 : retry_q;
	assign tmo_req = (retry0 < adre_pkg::MAX_RETRIES);

	always_comb begin
		if (use_dma) begin
			cmd_code = reading_q ? adre_pkg::CMD_READ_DMA : adre_pkg::CMD_WRITE_DMA;
		end else if (cur_min > 18'd512) begin
			cmd_code = reading_q ? adre_pkg::CMD_READ_MULTI : adre_pkg::CMD_WRITE_MULTI;
		end else begin
			cmd_code = reading_q ? adre_pkg::CMD_READ : adre_pkg::CMD_WRITE;
		end
	end

	assign div_start    = (state_q == ST_XFER && done_q == 18'd0 && !cfg.lba_enable)
		|| (state_q == ST_DIV1 && div_done);
	assign div_dividend = (state_q == ST_XFER) ? start_block_q : {15'd0, div_rem};
	assign div_divisor  = (state_q == ST_XFER) ? spc : {5'd0, spt_eff};

	adre_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		emit     = 1'b0;
		fin      = 1'b0;
		emit_res = '0;
		case (state_q)
			ST_DISP: begin
				if (item_q.action == adre_pkg::ACT_TIMEOUT) begin
					emit = 1'b1;
					if (tmo_req) begin
						emit_res.result_kind = adre_pkg::KIND_REQUEUE;
					end else begin
						emit_res.result_kind = adre_pkg::KIND_DONE;
						emit_res.failed      = 1'b1;
						emit_res.residual    = rem_q;
					end
				end else if (item_q.action == adre_pkg::ACT_IRQ) begin
					if (irq_err) begin
						emit = 1'b1;
						if (item_q.crc_error || dma_q) begin
							emit_res.result_kind = adre_pkg::KIND_REQUEUE;
						end else begin
							emit_res.result_kind = adre_pkg::KIND_DONE;
							emit_res.failed      = 1'b1;
							emit_res.residual    = rem_q;
						end
					end else if (!dma_q && reading_q) begin
						emit                  = 1'b1;
						emit_res.result_kind  = adre_pkg::KIND_RCHUNK;
						emit_res.chunk_offset = done_q;
						emit_res.chunk_bytes  = chunk_q;
					end
				end
			end
			ST_INTCHK: begin
				if (rem_q == 18'd0) begin
					emit                 = 1'b1;
					emit_res.result_kind = adre_pkg::KIND_DONE;
				end
			end
			ST_CMD: begin
				emit                  = 1'b1;
				emit_res.result_kind  = adre_pkg::KIND_CMD;
				emit_res.command_code = cmd_code;
				emit_res.cylinder     = cyl_q;
				emit_res.head         = hd_q;
				emit_res.sector       = sec_q;
				emit_res.sector_count = sec_cnt;
				emit_res.lba_mode     = cfg.lba_enable;
			end
			ST_TAIL: begin
				if (!dma_q && !reading_q) begin
					emit                  = 1'b1;
					emit_res.result_kind  = adre_pkg::KIND_WCHUNK;
					emit_res.chunk_offset = done_q;
					emit_res.chunk_bytes  = cur_min;
				end
			end
			ST_FIN: begin
				fin = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push = pend_v_q && (emit || fin);
	always_comb begin
		push_res      = pend_q;
		push_res.last = fin;
	end

	assign item_pop = (state_q == ST_IDLE) && item_valid && (oq_cnt_q <= 3'd2);
	assign empty    = (oq_cnt_q == 3'd0);
	assign do_pop   = pop && !empty;
	assign res      = oq_q[oq_rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			oq_q[oq_wr_q] <= push_res;
		end
		if (emit) begin
			pend_q <= emit_res;
		end
		if (item_pop) begin
			item_q <= item;
		end
		if (state_q == ST_XFER) begin
			cyl_q <= start_block_q[23:8];
			hd_q  <= start_block_q[27:24];
			sec_q <= start_block_q[7:0];
		end
		if (state_q == ST_DIV1 && div_done) begin
			cyl_q <= (div_quo[27:16] != 12'd0) ? 16'hffff : div_quo[15:0];
		end
		if (state_q == ST_DIV2 && div_done) begin
			hd_q  <= div_quo[3:0];
			sec_q <= div_rem[7:0] + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			start_block_q <= 28'd0;
			rem_q         <= 18'd0;
			done_q        <= 18'd0;
			chunk_q       <= 18'd0;
			reading_q     <= 1'b0;
			dma_q         <= 1'b0;
			retry_q       <= 3'd0;
			fallen_q      <= 1'b0;
			pend_v_q      <= 1'b0;
			oq_rd_q       <= 2'd0;
			oq_wr_q       <= 2'd0;
			oq_cnt_q      <= 3'd0;
		end else begin
			if (push) begin
				oq_wr_q <= oq_wr_q + 2'd1;
			end
			if (do_pop) begin
				oq_rd_q <= oq_rd_q + 2'd1;
			end
			oq_cnt_q <= oq_cnt_q + {2'd0, push} - {2'd0, do_pop};
			if (emit) begin
				pend_v_q <= 1'b1;
			end else if (fin) begin
				pend_v_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					case (item_q.action)
						adre_pkg::ACT_START: begin
							start_block_q <= item_q.block_address;
							rem_q         <= item_q.byte_count;
							done_q        <= 18'd0;
							chunk_q       <= 18'd0;
							reading_q     <= item_q.is_read;
							dma_q         <= 1'b0;
							retry_q       <= 3'd0;
							state_q       <= ST_XFER;
						end
						adre_pkg::ACT_RESTART: begin
							state_q <= ST_XFER;
						end
						adre_pkg::ACT_TIMEOUT: begin
							if (tmo_fb) begin
								fallen_q <= 1'b1;
							end
							retry_q <= (retry0 < adre_pkg::RETRY_SAT) ? retry0 + 3'd1
								: adre_pkg::RETRY_SAT;
							state_q <= ST_FIN;
						end
						default: begin
							if (irq_err) begin
								if (item_q.crc_error) begin
									if (retry_q < adre_pkg::RETRY_SAT) begin
										retry_q <= retry_q + 3'd1;
									end
									if (retry_q >= adre_pkg::MAX_RETRIES) begin
										fallen_q <= 1'b1;
									end
								end else if (dma_q) begin
									fallen_q <= 1'b1;
								end
								state_q <= ST_FIN;
							end else begin
								if (dma_q || reading_q) begin
									rem_q <= rem_sub;
								end
								done_q  <= done_q + chunk_q;
								state_q <= ST_INTCHK;
							end
						end
					endcase
				end
				ST_INTCHK: begin
					state_q <= (rem_q == 18'd0) ? ST_FIN : ST_XFER;
				end
				ST_XFER: begin
					if (done_q != 18'd0) begin
						state_q <= ST_TAIL;
					end else if (cfg.lba_enable) begin
						state_q <= ST_CMD;
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_done) begin
						state_q <= ST_CMD;
					end
				end
				ST_CMD: begin
					dma_q <= use_dma;
					if (use_dma) begin
						chunk_q <= rem_q;
					end
					state_q <= ST_TAIL;
				end
				ST_TAIL: begin
					if (!dma_q) begin
						chunk_q <= cur_min;
						if (!reading_q) begin
							rem_q <= (rem_q > cur_min) ? (rem_q - cur_min) : 18'd0;
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/ata_disk_request_engine_top.sv
// ATA disk request engine. Requests are taken through a two-entry input queue
// and results leave through a four-entry output queue, so either side may stall
// on its own. One request is worked at a time. A CHS start, unlike an LBA start,
// sends the address through two passes of a shared 28-step restoring divider.
// Interrupts and restarts that issue a fresh command do the same work as a start.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, as the block itself does not enforce this.
module ata_disk_request_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [27:0] block_address,
	input  logic [17:0] byte_count,
	input  logic        is_read,
	input  logic        dma_setup_ok,
	input  logic        status_error,
	input  logic        crc_error,
	input  logic        dma_done_ok,
	input  logic        data_ready,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  result_kind,
	output logic [2:0]  command_code,
	output logic [15:0] cylinder,
	output logic [3:0]  head,
	output logic [7:0]  sector,
	output logic [8:0]  sector_count,
	output logic        lba_mode,
	output logic [17:0] chunk_offset,
	output logic [17:0] chunk_bytes,
	output logic        failed,
	output logic [17:0] residual,
	output logic        last
);

	adre_pkg::cfg_t  cfg_q;
	adre_pkg::item_t in_item;
	adre_pkg::item_t item;
	logic            item_valid;
	logic            item_pop;
	adre_pkg::res_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lba_enable            <= 1'b1;
			cfg_q.sectors_per_track     <= 8'd63;
			cfg_q.head_count            <= 5'd16;
			cfg_q.sectors_per_interrupt <= 5'd1;
			cfg_q.dma_allowed           <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				adre_pkg::REG_LBA_ENABLE:  cfg_q.lba_enable            <= cfg_data[0];
				adre_pkg::REG_SPT:         cfg_q.sectors_per_track     <= cfg_data;
				adre_pkg::REG_HEAD_COUNT:  cfg_q.head_count            <= cfg_data[4:0];
				adre_pkg::REG_SPI:         cfg_q.sectors_per_interrupt <= cfg_data[4:0];
				adre_pkg::REG_DMA_ALLOWED: cfg_q.dma_allowed           <= cfg_data[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		in_item.action        = action;
		in_item.block_address = block_address;
		in_item.byte_count    = byte_count;
		in_item.is_read       = is_read;
		in_item.dma_setup_ok  = dma_setup_ok;
		in_item.status_error  = status_error;
		in_item.crc_error     = crc_error;
		in_item.dma_done_ok   = dma_done_ok;
		in_item.data_ready    = data_ready;
	end

	adre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	adre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign result_kind  = res.result_kind;
	assign command_code = res.command_code;
	assign cylinder     = res.cylinder;
	assign head         = res.head;
	assign sector       = res.sector;
	assign sector_count = res.sector_count;
	assign lba_mode     = res.lba_mode;
	assign chunk_offset = res.chunk_offset;
	assign chunk_bytes  = res.chunk_bytes;
	assign failed       = res.failed;
	assign residual     = res.residual;
	assign last         = res.last;

endmodule

FILE: bench/testbench.sv
module testbench;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        push;
	logic        full;
	logic [1:0]  action;
	logic [27:0] block_address;
	logic [17:0] byte_count;
	logic        is_read;
	logic        dma_setup_ok;
	logic        status_error;
	logic        crc_error;
	logic        dma_done_ok;
	logic        data_ready;
	logic        empty;
	logic        pop;
	logic [2:0]  result_kind;
	logic [2:0]  command_code;
	logic [15:0] cylinder;
	logic [3:0]  head;
	logic [7:0]  sector;
	logic [8:0]  sector_count;
	logic        lba_mode;
	logic [17:0] chunk_offset;
	logic [17:0] chunk_bytes;
	logic        failed;
	logic [17:0] residual;
	logic        last;

	ata_disk_request_engine_top u_dut (.*);

	adre_pkg::cfg_t cfg;
	logic [27:0] req_block;
	logic [17:0] bytes_left;
	logic [17:0] bytes_done;
	logic [17:0] chunk_len;
	logic        req_reading;
	logic        dma_active;
	logic [2:0]  retries;
	logic        pio_forced;
	logic        dma_dropped;

	adre_pkg::res_t pending_results[$];
	int     error_count;
	int     cycle_count;
	bit     hold_pop;
	int     hold_cycles;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 1500000) begin
				$display("ata_disk_request_engine_top verification failed");
				$finish;
			end
		end
	end

	function automatic logic [17:0] sub_floor(logic [17:0] a, logic [17:0] b);
		return (a > b) ? a - b : 18'd0;
	endfunction

	function automatic adre_pkg::res_t blank_result(logic [2:0] kind);
		adre_pkg::res_t r;
		r = '0;
		r.result_kind = kind;
		return r;
	endfunction

	task automatic plan_transfer(logic setup_ok, inout adre_pkg::res_t outs[$]);
		int unsigned spi, xfer, blk, cnt, spt, hc, spc, cyl, hd, sec, cur;
		logic [2:0] cmd;
		adre_pkg::res_t r;
		spi = (cfg.sectors_per_interrupt != 0) ? cfg.sectors_per_interrupt : 1;
		xfer = spi * 512;
		if (bytes_done == 0) begin
			blk = req_block;
			cnt = (bytes_left + 511) >> 9;
			if (cnt > adre_pkg::MAX_SECTORS) cnt = adre_pkg::MAX_SECTORS;
			if (cfg.lba_enable) begin
				sec = blk & 8'hff;
				cyl = (blk >> 8) & 16'hffff;
				hd = (blk >> 24) & 4'hf;
			end else begin
				spt = (cfg.sectors_per_track != 0) ? cfg.sectors_per_track : 1;
				hc = (cfg.head_count != 0) ? cfg.head_count : 1;
				spc = spt * hc;
				cyl = blk / spc;
				if (cyl > 16'hffff) cyl = 16'hffff;
				hd = ((blk % spc) / spt) & 4'hf;
				sec = (blk % spt) + 1;
			end
			cur = (bytes_left < xfer) ? bytes_left : xfer;
			dma_active = 0;
			if (cfg.dma_allowed && !dma_dropped && setup_ok) begin
				dma_active = 1;
				cmd = req_reading ? adre_pkg::CMD_READ_DMA : adre_pkg::CMD_WRITE_DMA;
				cur = bytes_left;
			end else if (cur > 512) begin
				cmd = req_reading ? adre_pkg::CMD_READ_MULTI : adre_pkg::CMD_WRITE_MULTI;
			end else begin
				cmd = req_reading ? adre_pkg::CMD_READ : adre_pkg::CMD_WRITE;
			end
			chunk_len = cur;
			r = blank_result(adre_pkg::KIND_CMD);
			r.command_code = cmd;
			r.cylinder = cyl;
			r.head = hd;
			r.sector = sec;
			r.sector_count = cnt;
			r.lba_mode = cfg.lba_enable;
			outs.push_back(r);
		end
		if (dma_active) return;
		chunk_len = (bytes_left < xfer) ? bytes_left : xfer;
		if (req_reading) return;
		r = blank_result(adre_pkg::KIND_WCHUNK);
		r.chunk_offset = bytes_done;
		r.chunk_bytes = chunk_len;
		outs.push_back(r);
		bytes_left = sub_floor(bytes_left, chunk_len);
	endtask

	task automatic predict_request(adre_pkg::item_t it);
		adre_pkg::res_t outs[$];
		adre_pkg::res_t r;
		logic err;
		logic fail;
		logic [2:0] old;
		fail = 0;
		case (it.action)
			adre_pkg::ACT_START: begin
				req_block = it.block_address;
				bytes_left = it.byte_count;
				bytes_done = 0;
				chunk_len = 0;
				req_reading = it.is_read;
				dma_active = 0;
				retries = 0;
				pio_forced = 0;
				plan_transfer(it.dma_setup_ok, outs);
			end
			adre_pkg::ACT_IRQ: begin
				err = it.status_error || (dma_active && !it.dma_done_ok);
				if (!err && !dma_active && req_reading && !it.data_ready) err = 1;
				if (err && it.crc_error) begin
					old = retries;
					if (retries < adre_pkg::RETRY_SAT) retries++;
					if (old >= adre_pkg::MAX_RETRIES) dma_dropped = 1;
					outs.push_back(blank_result(adre_pkg::KIND_REQUEUE));
				end else if (err && dma_active) begin
					pio_forced = 1;
					dma_dropped = 1;
					outs.push_back(blank_result(adre_pkg::KIND_REQUEUE));
				end else begin
					fail = err;
					if (!fail) begin
						if (!dma_active && req_reading) begin
							r = blank_result(adre_pkg::KIND_RCHUNK);
							r.chunk_offset = bytes_done;
							r.chunk_bytes = chunk_len;
							outs.push_back(r);
							bytes_left = sub_floor(bytes_left, chunk_len);
						end
						if (dma_active) bytes_left = sub_floor(bytes_left, chunk_len);
						bytes_done = bytes_done + chunk_len;
					end
					if (!fail && bytes_left > 0) begin
						plan_transfer(it.dma_setup_ok, outs);
					end else begin
						r = blank_result(adre_pkg::KIND_DONE);
						r.failed = fail;
						r.residual = bytes_left;
						outs.push_back(r);
					end
				end
			end
			adre_pkg::ACT_TIMEOUT: begin
				if (dma_active && retries == adre_pkg::MAX_RETRIES) begin
					dma_dropped = 1;
					retries = 0;
				end
				old = retries;
				if (retries < adre_pkg::RETRY_SAT) retries++;
				if (old < adre_pkg::MAX_RETRIES) begin
					outs.push_back(blank_result(adre_pkg::KIND_REQUEUE));
				end else begin
					r = blank_result(adre_pkg::KIND_DONE);
					r.failed = 1;
					r.residual = bytes_left;
					outs.push_back(r);
				end
			end
			default: plan_transfer(it.dma_setup_ok, outs);
		endcase
		if (outs.size() > 0) outs[outs.size() - 1].last = 1;
		foreach (outs[i]) pending_results.push_back(outs[i]);
	endtask

	task automatic send_request(adre_pkg::item_t it);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
		@(negedge clk);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(negedge clk);
		end
		push <= 1;
		action <= it.action;
		block_address <= it.block_address;
		byte_count <= it.byte_count;
		is_read <= it.is_read;
		dma_setup_ok <= it.dma_setup_ok;
		status_error <= it.status_error;
		crc_error <= it.crc_error;
		dma_done_ok <= it.dma_done_ok;
		data_ready <= it.data_ready;
		do @(posedge clk); while (full);
		predict_request(it);
	endtask

	task automatic drop_push();
		@(negedge clk);
		push <= 0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			adre_pkg::REG_LBA_ENABLE:  cfg.lba_enable = val[0];
			adre_pkg::REG_SPT:         cfg.sectors_per_track = val;
			adre_pkg::REG_HEAD_COUNT:  cfg.head_count = val[4:0];
			adre_pkg::REG_SPI:         cfg.sectors_per_interrupt = val[4:0];
			adre_pkg::REG_DMA_ALLOWED: cfg.dma_allowed = val[0];
			default: ;
		endcase
	endtask

	task automatic drain_results();
		drop_push();
		while (pending_results.size() > 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_config(logic lba, logic [7:0] spt, logic [4:0] hc,
			logic [4:0] spi, logic dma);
		drain_results();
		write_reg(adre_pkg::REG_LBA_ENABLE, lba);
		write_reg(adre_pkg::REG_SPT, spt);
		write_reg(adre_pkg::REG_HEAD_COUNT, hc);
		write_reg(adre_pkg::REG_SPI, spi);
		write_reg(adre_pkg::REG_DMA_ALLOWED, dma);
	endtask

	function automatic adre_pkg::item_t make_request(logic [1:0] act, logic [27:0] blk,
			logic [17:0] bytes, logic rd, logic [4:0] flags);
		adre_pkg::item_t it;
		it.action = act;
		it.block_address = blk;
		it.byte_count = bytes;
		it.is_read = rd;
		{it.dma_setup_ok, it.status_error, it.crc_error, it.dma_done_ok,
			it.data_ready} = flags;
		return it;
	endfunction

	function automatic adre_pkg::item_t random_request(logic [1:0] act);
		adre_pkg::item_t it;
		logic [17:0] bytes;
		case ($urandom_range(0, 5))
			0: bytes = 18'd131072;
			1: bytes = $urandom_range(0, 18'h3ffff);
			2: bytes = $urandom_range(0, 256) * 512;
			default: bytes = $urandom_range(0, 16) * 512;
		endcase
		it.action = act;
		it.block_address = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000);
		it.byte_count = bytes;
		it.is_read = $urandom_range(0, 1);
		it.dma_setup_ok = $urandom_range(0, 1);
		it.status_error = $urandom_range(0, 5) == 0;
		it.crc_error = $urandom_range(0, 1);
		it.dma_done_ok = $urandom_range(0, 5) != 0;
		it.data_ready = $urandom_range(0, 5) != 0;
		return it;
	endfunction

	task automatic test_lba_requests();
		set_config(1, 63, 16, 1, 1);
		send_request(make_request(adre_pkg::ACT_START, 28'hfffffff, 18'd131072, 1, 5'b10011));
		send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b00011));
		send_request(make_request(adre_pkg::ACT_START, 28'h0, 18'd0, 0, 5'b00000));
		send_request(make_request(adre_pkg::ACT_START, 28'h1234567, 18'd1024, 0, 5'b00001));
		send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b00001));
		send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b00001));
		send_request(make_request(adre_pkg::ACT_START, 28'h55, 18'h3ffff, 1, 5'b00001));
		send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b00000));
	endtask

	task automatic test_chs_geometry();
		set_config(0, 0, 0, 0, 0);
		send_request(make_request(adre_pkg::ACT_START, 28'hfffffff, 18'd512, 1, 5'b10000));
		set_config(0, 255, 16, 16, 0);
		send_request(make_request(adre_pkg::ACT_START, 28'hfffffff, 18'd8192, 0, 5'b00001));
		send_request(make_request(adre_pkg::ACT_RESTART, 0, 0, 0, 5'b00001));
		set_config(0, 17, 31, 5, 1);
		send_request(make_request(adre_pkg::ACT_START, 28'd123456, 18'd4096, 1, 5'b00001));
		send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b00001));
	endtask

	task automatic test_error_retries();
		set_config(1, 63, 16, 1, 1);
		send_request(make_request(adre_pkg::ACT_START, 28'd100, 18'd2048, 1, 5'b10000));
		repeat (5) send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b01100));
		send_request(make_request(adre_pkg::ACT_RESTART, 0, 0, 0, 5'b10000));
		send_request(make_request(adre_pkg::ACT_START, 28'd7, 18'd1024, 0, 5'b10000));
		send_request(make_request(adre_pkg::ACT_IRQ, 0, 0, 0, 5'b00000));
		repeat (5) send_request(make_request(adre_pkg::ACT_TIMEOUT, 0, 0, 0, 5'b00000));
	endtask

	task automatic test_random_traffic(int count);
		int n;
		logic [1:0] act;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 199) == 0) begin
				set_config($urandom_range(0, 1), $urandom_range(0, 255),
					$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
			end
			case ($urandom_range(0, 9))
				0, 1:    act = adre_pkg::ACT_START;
				2:       act = adre_pkg::ACT_TIMEOUT;
				3:       act = adre_pkg::ACT_RESTART;
				default: act = adre_pkg::ACT_IRQ;
			endcase
			send_request(random_request(act));
			n++;
		end
	endtask

	task automatic test_backpressure();
		set_config(1, 63, 16, 1, 0);
		hold_cycles = 300;
		hold_pop = 1;
		repeat (12) send_request(random_request(adre_pkg::ACT_IRQ));
		drop_push();
		wait (hold_pop == 0);
	endtask

	always @(posedge clk) begin
		if (hold_pop && hold_cycles > 0) hold_cycles <= hold_cycles - 1;
		else if (hold_pop) hold_pop <= 0;
	end

	initial begin
		int stall;
		adre_pkg::res_t want;
		forever begin
			@(negedge clk);
			if (hold_pop) begin
				pop <= 0;
			end else begin
				stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
				if (stall > 0) begin
					pop <= 0;
					repeat (stall) @(negedge clk);
				end
				pop <= 1;
				do @(posedge clk); while (empty);
				if (pending_results.size() == 0) begin
					$error("unexpected result kind %0d", result_kind);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (result_kind !== want.result_kind) begin
						$error("result_kind exp %0d got %0d", want.result_kind, result_kind);
						error_count++;
					end
					if (command_code !== want.command_code) begin
						$error("command_code exp %0d got %0d", want.command_code, command_code);
						error_count++;
					end
					if (cylinder !== want.cylinder) begin
						$error("cylinder exp %0d got %0d", want.cylinder, cylinder);
						error_count++;
					end
					if (head !== want.head) begin
						$error("head exp %0d got %0d", want.head, head);
						error_count++;
					end
					if (sector !== want.sector) begin
						$error("sector exp %0d got %0d", want.sector, sector);
						error_count++;
					end
					if (sector_count !== want.sector_count) begin
						$error("sector_count exp %0d got %0d", want.sector_count, sector_count);
						error_count++;
					end
					if (lba_mode !== want.lba_mode) begin
						$error("lba_mode exp %0d got %0d", want.lba_mode, lba_mode);
						error_count++;
					end
					if (chunk_offset !== want.chunk_offset) begin
						$error("chunk_offset exp %0d got %0d", want.chunk_offset, chunk_offset);
						error_count++;
					end
					if (chunk_bytes !== want.chunk_bytes) begin
						$error("chunk_bytes exp %0d got %0d", want.chunk_bytes, chunk_bytes);
						error_count++;
					end
					if (failed !== want.failed) begin
						$error("failed exp %0d got %0d", want.failed, failed);
						error_count++;
					end
					if (residual !== want.residual) begin
						$error("residual exp %0d got %0d", want.residual, residual);
						error_count++;
					end
					if (last !== want.last) begin
						$error("last exp %0d got %0d", want.last, last);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		error_count = 0;
		hold_pop = 0;
		hold_cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = adre_pkg::REG_LBA_ENABLE;
		cfg_data = 0;
		push = 0;
		pop = 0;
		action = adre_pkg::ACT_START;
		block_address = 0;
		byte_count = 0;
		is_read = 0;
		dma_setup_ok = 0;
		status_error = 0;
		crc_error = 0;
		dma_done_ok = 0;
		data_ready = 0;
		cfg = '{lba_enable: 1, sectors_per_track: 63, head_count: 16,
			sectors_per_interrupt: 1, dma_allowed: 1};
		req_block = 0;
		bytes_left = 0;
		bytes_done = 0;
		chunk_len = 0;
		req_reading = 0;
		dma_active = 0;
		retries = 0;
		pio_forced = 0;
		dma_dropped = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		test_lba_requests();
		test_chs_geometry();
		test_error_retries();
		test_backpressure();
		set_config(1, 63, 16, 4, 1);
		test_random_traffic(500);
		set_config(0, 63, 16, 16, 1);
		test_random_traffic(500);
		drain_results();
		if (error_count == 0) begin
			$display("ata_disk_request_engine_top verification clean");
		end else begin
			$display("ata_disk_request_engine_top verification failed");
		end
		$finish;
	end

endmodule

FILE: ata_disk_request_engine_top.f
hw/rtl/adre_pkg.sv
hw/rtl/adre_front.sv
hw/rtl/adre_div.sv
hw/rtl/adre_back.sv
hw/rtl/ata_disk_request_engine_top.sv
bench/testbench.sv
